[rtl/assert_macros.svh]
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define FPI_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// condition that must never hold
`define FPI_NEVER(lbl, expr, msg) \
	`FPI_ASSERT(lbl, !(expr), msg)

`endif

[rtl/fpi_pkg.sv]
// shared types and constants of the float power by integer block
`default_nettype none

package fpi_pkg;

	typedef enum logic [0:0] {
		OP_MUL = 1'b0,
		OP_DIV = 1'b1
	} fpi_op_t;

	// one request to the shared floating-point unit
	typedef struct packed {
		fpi_op_t     op;
		logic        fmt64;
		logic [63:0] a;
		logic [63:0] b;
	} fpi_req_t;

	localparam logic [63:0] ONE_F64 = 64'h3FF0_0000_0000_0000;
	localparam logic [63:0] ONE_F32 = 64'h0000_0000_3F80_0000;

endpackage

`default_nettype wire

[rtl/float_power_by_integer.sv]
// float power by integer: square-and-multiply sequencer around a shared fp unit
// an fp multiply takes longer with subnormal operands or results; the reciprocal for a
//   negative exponent is one more divide on the same unit
// an item costs one multiply per set exponent bit plus one squaring per bit below the top
//   one, all on the single fpi_fpu
// one item at a time; a finished result waits in the output register while the next is taken
// reset: asynchronous active low; idle, no result pending, precision_mode back to binary64
`default_nettype none
`include "assert_macros.svh"

module float_power_by_integer (
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               cfg_wr_en,
	input  logic               cfg_wr_data,
	// input transfer
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [63:0]        base_bits,
	input  logic signed [31:0] exponent,
	// output transfer
	output logic               out_valid,
	input  logic               out_ready,
	output logic [63:0]        result_bits
);

	typedef enum logic [7:0] {
		S_IDLE     = 8'b0000_0001,
		S_BIT      = 8'b0000_0010,
		S_WAIT_ACC = 8'b0000_0100,
		S_SHIFT    = 8'b0000_1000,
		S_WAIT_SQ  = 8'b0001_0000,
		S_FIN      = 8'b0010_0000,
		S_WAIT_DIV = 8'b0100_0000,
		S_OUT      = 8'b1000_0000
	} state_t;

	state_t            state_q;
	logic              precision_mode_q;
	logic              fmt_q;      // format of the item in flight
	logic [63:0]       x_q;        // running base, squared each step
	logic [63:0]       acc_q;      // running result
	logic [31:0]       mag_q;      // exponent magnitude, consumed low bit first
	logic              neg_q;
	logic              out_valid_q;
	logic [63:0]       result_bits_q;

	logic [31:0]       exp_u;
	logic              in_xfer;
	logic              out_load;   // result moves into the output register
	logic              fpu_wait;   // sequencer waits on the shared unit
	logic              fpu_start;
	fpi_pkg::fpi_req_t fpu_req;
	logic              fpu_done;
	logic [63:0]       fpu_result;

	assign exp_u   = unsigned'(exponent);
	assign in_ready = (state_q == S_IDLE);
	assign in_xfer  = in_valid && in_ready;
	// load once the previous result is gone or leaves in this cycle
	assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ready);
	assign fpu_wait = (state_q == S_WAIT_ACC) || (state_q == S_WAIT_SQ)
		|| (state_q == S_WAIT_DIV);

	// request to the shared unit for the current step
	always_comb begin
		fpu_start     = 1'b0;
		fpu_req.op    = fpi_pkg::OP_MUL;
		fpu_req.fmt64 = fmt_q;
		fpu_req.a     = acc_q;
		fpu_req.b     = x_q;
		unique case (state_q)
			S_BIT: begin
				// acc = acc * x when the current bit is set
				fpu_start = mag_q[0];
			end
			S_SHIFT: begin
				// x = x * x while higher bits remain
				fpu_start = (mag_q[31:1] != '0);
				fpu_req.a = x_q;
			end
			S_FIN: begin
				// acc = 1 / acc for a negative exponent
				fpu_start  = neg_q;
				fpu_req.op = fpi_pkg::OP_DIV;
				fpu_req.a  = fmt_q ? fpi_pkg::ONE_F64 : fpi_pkg::ONE_F32;
				fpu_req.b  = acc_q;
			end
			default: begin
			end
		endcase
	end

	fpi_fpu u_fpu (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (fpu_start),
		.req    (fpu_req),
		.done   (fpu_done),
		.result (fpu_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			precision_mode_q <= 1'b1;
		end else if (cfg_wr_en) begin
			precision_mode_q <= cfg_wr_data;
		end
	end

	// output valid: set on load, cleared when the transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						fmt_q   <= precision_mode_q;
						x_q     <= precision_mode_q ? base_bits : {32'b0, base_bits[31:0]};
						acc_q   <= precision_mode_q ? fpi_pkg::ONE_F64 : fpi_pkg::ONE_F32;
						// most negative exponent wraps to 2^31, read as unsigned
						mag_q   <= exp_u[31] ? (32'd0 - exp_u) : exp_u;
						neg_q   <= exp_u[31];
						state_q <= S_BIT;
					end
				end
				S_BIT: begin
					state_q <= mag_q[0] ? S_WAIT_ACC : S_SHIFT;
				end
				S_WAIT_ACC: begin
					if (fpu_done) begin
						acc_q   <= fpu_result;
						state_q <= S_SHIFT;
					end
				end
				S_SHIFT: begin
					mag_q   <= {1'b0, mag_q[31:1]};
					state_q <= (mag_q[31:1] != '0) ? S_WAIT_SQ : S_FIN;
				end
				S_WAIT_SQ: begin
					if (fpu_done) begin
						x_q     <= fpu_result;
						state_q <= S_BIT;
					end
				end
				S_FIN: begin
					state_q <= neg_q ? S_WAIT_DIV : S_OUT;
				end
				S_WAIT_DIV: begin
					if (fpu_done) begin
						acc_q   <= fpu_result;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					// load the output register once the previous result is gone
					if (out_load) begin
						result_bits_q <= acc_q;
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign result_bits = result_bits_q;

	`FPI_ASSERT(a_done_in_wait, fpu_done |-> fpu_wait, "fpu done outside a wait state")
	`FPI_ASSERT(a_accept_busy, in_xfer |=> !in_ready, "ready right after a transfer")
	`FPI_NEVER(a_out_overrun, out_valid_q && !out_ready && out_load, "pending result overwritten")

endmodule

`default_nettype wire

[rtl/fpi_fpu.sv]
// multi-cycle ieee multiply and divide unit, binary32 or binary64, round to nearest even
`default_nettype none
`include "assert_macros.svh"

module fpi_fpu (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  fpi_pkg::fpi_req_t  req,
	output logic               done,
	output logic [63:0]        result
);

	typedef enum logic [7:0] {
		F_IDLE   = 8'b0000_0001,
		F_NORM   = 8'b0000_0010,
		F_MUL    = 8'b0000_0100,
		F_ALIGN  = 8'b0000_1000,
		F_DIV    = 8'b0001_0000,
		F_DENORM = 8'b0010_0000,
		F_ROUND  = 8'b0100_0000,
		F_DONE   = 8'b1000_0000
	} fstate_t;

	typedef struct packed {
		logic               sgn;
		logic               nan;
		logic               inf;
		logic               zero;
		logic signed [12:0] e;
		logic [52:0]        m;
	} unp_t;

	function automatic unp_t unpack(input logic fmt64, input logic [63:0] x);
		unp_t               u;
		logic [10:0]        ef;
		logic [51:0]        fr;
		logic [10:0]        ef_max;
		logic signed [12:0] bias;
		if (fmt64) begin
			u.sgn  = x[63];
			ef     = x[62:52];
			fr     = x[51:0];
			ef_max = 11'h7FF;
			bias   = 13'sd1023;
		end else begin
			u.sgn  = x[31];
			ef     = {3'b000, x[30:23]};
			fr     = {x[22:0], 29'b0};
			ef_max = 11'h0FF;
			bias   = 13'sd127;
		end
		u.nan  = (ef == ef_max) && (fr != '0);
		u.inf  = (ef == ef_max) && (fr == '0);
		u.zero = (ef == '0) && (fr == '0);
		u.m    = {ef != '0, fr};
		u.e    = $signed({2'b00, (ef == '0) ? 11'd1 : ef}) - bias;
		return u;
	endfunction

	function automatic logic [63:0] quiet(input logic fmt64, input logic [63:0] x);
		return fmt64 ? (x | 64'h0008_0000_0000_0000) : {32'b0, x[31:0] | 32'h0040_0000};
	endfunction

	function automatic logic [63:0] inf_pat(input logic fmt64, input logic s);
		return fmt64 ? {s, 11'h7FF, 52'b0} : {32'b0, s, 8'hFF, 23'b0};
	endfunction

	function automatic logic [63:0] zero_pat(input logic fmt64, input logic s);
		return fmt64 ? {s, 63'b0} : {32'b0, s, 31'b0};
	endfunction

	function automatic logic [63:0] dnan_pat(input logic fmt64);
		return fmt64 ? 64'hFFF8_0000_0000_0000 : 64'h0000_0000_FFC0_0000;
	endfunction

	fstate_t            state_q;
	fpi_pkg::fpi_op_t   op_q;
	logic               fmt_q;
	logic               sgn_q;
	logic signed [12:0] ea_q, eb_q, exp_q;
	logic [52:0]        ma_q, mb_q;
	logic [105:0]       prod_q;
	logic [5:0]         cnt_q;
	logic [53:0]        rem_q;
	logic [55:0]        sig_q;
	logic               stk_q;
	logic [63:0]        result_q;

	unp_t               ua, ub;
	logic               res_sgn;
	logic               special;
	logic [63:0]        special_val;

	logic signed [12:0] emin, emax, bias;
	logic [55:0]        mb_ext;
	logic [13:0]        chunk;
	logic [66:0]        pp;
	logic [105:0]       pp_sh;
	logic               ge;
	logic [53:0]        nxt_rem;

	logic               lsb, rb, st, inc;
	logic [56:0]        rsum;
	logic               lead;
	logic signed [12:0] rexp, ebias;
	logic [10:0]        bexp;
	logic [63:0]        rpack;

	// operand decode and special cases at request time
	always_comb begin
		ua      = unpack(req.fmt64, req.a);
		ub      = unpack(req.fmt64, req.b);
		res_sgn = ua.sgn ^ ub.sgn;
		special     = 1'b1;
		special_val = '0;
		if (ua.nan) begin
			special_val = quiet(req.fmt64, req.a);
		end else if (ub.nan) begin
			special_val = quiet(req.fmt64, req.b);
		end else if (req.op == fpi_pkg::OP_MUL) begin
			priority if ((ua.inf && ub.zero) || (ua.zero && ub.inf)) begin
				special_val = dnan_pat(req.fmt64);
			end else if (ua.inf || ub.inf) begin
				special_val = inf_pat(req.fmt64, res_sgn);
			end else if (ua.zero || ub.zero) begin
				special_val = zero_pat(req.fmt64, res_sgn);
			end else begin
				special = 1'b0;
			end
		end else begin
			priority if ((ua.inf && ub.inf) || (ua.zero && ub.zero)) begin
				special_val = dnan_pat(req.fmt64);
			end else if (ua.inf || ub.zero) begin
				special_val = inf_pat(req.fmt64, res_sgn);
			end else if (ub.inf || ua.zero) begin
				special_val = zero_pat(req.fmt64, res_sgn);
			end else begin
				special = 1'b0;
			end
		end
	end

	// format limits
	always_comb begin
		emin = fmt_q ? -13'sd1022 : -13'sd126;
		emax = fmt_q ? 13'sd1023 : 13'sd127;
		bias = fmt_q ? 13'sd1023 : 13'sd127;
	end

	// one 53x14 partial product per cycle
	always_comb begin
		mb_ext = {3'b000, mb_q};
		unique case (cnt_q[1:0])
			2'd0: chunk = mb_ext[13:0];
			2'd1: chunk = mb_ext[27:14];
			2'd2: chunk = mb_ext[41:28];
			default: chunk = mb_ext[55:42];
		endcase
		pp = {14'b0, ma_q} * {53'b0, chunk};
		unique case (cnt_q[1:0])
			2'd0: pp_sh = {39'b0, pp};
			2'd1: pp_sh = {25'b0, pp, 14'b0};
			2'd2: pp_sh = {11'b0, pp, 28'b0};
			default: pp_sh = {pp[63:0], 42'b0};
		endcase
	end

	// restoring divide step
	always_comb begin
		ge      = rem_q >= {1'b0, mb_q};
		nxt_rem = ge ? (rem_q - {1'b0, mb_q}) : rem_q;
	end

	// round to nearest even and pack
	always_comb begin
		if (fmt_q) begin
			lsb = sig_q[3];
			rb  = sig_q[2];
			st  = (|sig_q[1:0]) | stk_q;
		end else begin
			lsb = sig_q[32];
			rb  = sig_q[31];
			st  = (|sig_q[30:0]) | stk_q;
		end
		inc   = rb & (st | lsb);
		rsum  = {1'b0, sig_q} + (fmt_q ? {53'b0, inc, 3'b000} : {24'b0, inc, 32'b0});
		lead  = rsum[56] | rsum[55];
		rexp  = exp_q + $signed({12'b0, rsum[56]});
		ebias = rexp + bias;
		bexp  = lead ? ebias[10:0] : 11'd0;
		if (rexp > emax) begin
			rpack = inf_pat(fmt_q, sgn_q);
		end else if (fmt_q) begin
			rpack = {sgn_q, bexp, rsum[54:3]};
		end else begin
			rpack = {32'b0, sgn_q, bexp[7:0], rsum[54:32]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (start) begin
						op_q  <= req.op;
						fmt_q <= req.fmt64;
						sgn_q <= res_sgn;
						ma_q  <= ua.m;
						mb_q  <= ub.m;
						ea_q  <= ua.e;
						eb_q  <= ub.e;
						if (special) begin
							result_q <= special_val;
							state_q  <= F_DONE;
						end else begin
							state_q <= F_NORM;
						end
					end
				end
				F_NORM: begin
					// subnormal operands shift up one place a cycle
					if (!ma_q[52]) begin
						ma_q <= {ma_q[51:0], 1'b0};
						ea_q <= ea_q - 13'sd1;
					end
					if (!mb_q[52]) begin
						mb_q <= {mb_q[51:0], 1'b0};
						eb_q <= eb_q - 13'sd1;
					end
					if (ma_q[52] && mb_q[52]) begin
						if (op_q == fpi_pkg::OP_MUL) begin
							exp_q   <= ea_q + eb_q;
							prod_q  <= '0;
							cnt_q   <= '0;
							state_q <= F_MUL;
						end else begin
							cnt_q <= 6'd55;
							sig_q <= '0;
							if (ma_q >= mb_q) begin
								rem_q <= {1'b0, ma_q};
								exp_q <= ea_q - eb_q;
							end else begin
								rem_q <= {ma_q, 1'b0};
								exp_q <= ea_q - eb_q - 13'sd1;
							end
							state_q <= F_DIV;
						end
					end
				end
				F_MUL: begin
					prod_q <= prod_q + pp_sh;
					cnt_q  <= cnt_q + 6'd1;
					if (cnt_q[1:0] == 2'd3) begin
						state_q <= F_ALIGN;
					end
				end
				F_ALIGN: begin
					if (prod_q[105]) begin
						sig_q <= prod_q[105:50];
						stk_q <= |prod_q[49:0];
						exp_q <= exp_q + 13'sd1;
					end else begin
						sig_q <= prod_q[104:49];
						stk_q <= |prod_q[48:0];
					end
					state_q <= F_DENORM;
				end
				F_DIV: begin
					rem_q <= {nxt_rem[52:0], 1'b0};
					sig_q <= {sig_q[54:0], ge};
					if (cnt_q == '0) begin
						stk_q   <= nxt_rem != '0;
						state_q <= F_DENORM;
					end else begin
						cnt_q <= cnt_q - 6'd1;
					end
				end
				F_DENORM: begin
					priority if (exp_q > emax) begin
						result_q <= inf_pat(fmt_q, sgn_q);
						state_q  <= F_DONE;
					end else if (exp_q >= emin) begin
						state_q <= F_ROUND;
					end else if ((emin - exp_q) > 13'sd57) begin
						// far below the smallest subnormal: only sticky survives
						sig_q   <= '0;
						stk_q   <= 1'b1;
						exp_q   <= emin;
						state_q <= F_ROUND;
					end else begin
						sig_q <= {1'b0, sig_q[55:1]};
						stk_q <= stk_q | sig_q[0];
						exp_q <= exp_q + 13'sd1;
					end
				end
				F_ROUND: begin
					result_q <= rpack;
					state_q  <= F_DONE;
				end
				F_DONE: begin
					state_q <= F_IDLE;
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	assign done   = (state_q == F_DONE);
	assign result = result_q;

	`FPI_ASSERT(a_start_idle, start |-> (state_q == F_IDLE), "fpu started while busy")
	`FPI_ASSERT(a_round_range, (state_q == F_ROUND) |-> (exp_q >= emin), "rounding below emin")

endmodule

`default_nettype wire
